// ===== rtl/core/first_fit_heap_allocator_assert.svh =====
// Assertion macros for the first-fit heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FFHA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

   localparam int ADDR_BITS        = 22;
   localparam int HEAP_BITS        = 23;
   localparam int MINP_BITS        = 13;
   localparam int MAX_BLOCKS_DEF   = 256;
   localparam int HEADER_BYTES_DEF = 12;
   localparam int PAGE_ORDER       = 10;
   localparam logic [MINP_BITS-1:0] MIN_PART_RESET = 13'h20;
   localparam logic [HEAP_BITS-1:0] HEAP_RESET     = HEAP_BITS'(4096 << PAGE_ORDER);
   localparam logic [HEAP_BITS-1:0] HEAP_LIMIT     = HEAP_BITS'(1 << ADDR_BITS);

   typedef enum logic [0:0] {
      CSR_HEAP_BYTES = 1'b0,
      CSR_MIN_PART   = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_FIT   = 2'd1,
      STAT_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
      logic                 used;
   } entry_type;

   typedef enum logic [3:0] {
      FS_INIT,
      FS_IDLE,
      FS_SCAN_RD,
      FS_SCAN_CHK,
      FS_SHUP_RD,
      FS_SHUP_WR,
      FS_WR_NEW,
      FS_WR_ENT,
      FS_PRV_RD,
      FS_PRV_CHK,
      FS_NXT_RD,
      FS_NXT_CHK,
      FS_MERGE,
      FS_SHDN_RD,
      FS_SHDN_WR,
      FS_DONE
   } state_type;

endpackage

// ===== rtl/core/ffha_req_if.sv =====
// Request channel interface: allocate or free commands.
interface ffha_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [ffha_pkg::ADDR_BITS-1:0]  request_size;
   logic [ffha_pkg::ADDR_BITS-1:0]  free_address;

   modport source (output valid, output command, output request_size,
                   output free_address, input ready);
   modport sink   (input valid, input command, input request_size,
                   input free_address, output ready);
endinterface

// ===== rtl/core/ffha_rsp_if.sv =====
// Response channel interface: granted offset and status.
interface ffha_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ffha_pkg::ADDR_BITS-1:0]  data_address;
   logic [1:0]                      status;

   modport source (output valid, output data_address, output status, input ready);
   modport sink   (input valid, input data_address, input status, output ready);
endinterface

// ===== rtl/core/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing; block table kept in one memory.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  req_bus  | in  | valid/ready        | command, request_size, free_address
//  rsp_bus  | out | valid/ready        | data_address, status
//  csr      | in  | csr_wr_en          | csr_index (0 heap_bytes, 1 min_part)
//
// One request at a time. The table memory has a registered read, so every
// entry touched takes a read state and then a check or write state: a scan
// runs SCAN_RD and SCAN_CHK per entry, a split shifts the upper entries
// up through SHUP_RD and SHUP_WR, a merge shifts them down the same way
// through SHDN_RD and SHDN_WR. Scan and shift cover disjoint table parts.
// Reset (synchronous) and any heap_bytes write spend one cycle writing
// entry 0 before requests are taken again. A result waits in the output
// register while the next request is already being worked on.
module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ffha_req_if.sink                        req_bus,
   ffha_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [0:0]                      csr_index,
   input  logic [ffha_pkg::HEAP_BITS-1:0]  csr_wdata
);

   localparam int AW = ffha_pkg::ADDR_BITS;
   localparam int NW = AW + 1;                       // need / compare width
   localparam int SW = AW + 2;                       // merge sum width
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [NW-1:0] HDR_N = NW'(HEADER_BYTES);
   localparam logic [SW-1:0] HDR_S = SW'(HEADER_BYTES);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

   ffha_pkg::state_type state_ff, state_in;

   // block table
   ffha_pkg::entry_type mem [MAX_BLOCKS];
   ffha_pkg::entry_type rdata_ff;
   logic [IW-1:0]       rd_addr;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   ffha_pkg::entry_type wr_data;

   // configuration
   logic [ffha_pkg::HEAP_BITS-1:0] heap_ff, heap_in;
   logic [ffha_pkg::MINP_BITS-1:0] minp_ff, minp_in;

   // request context
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                cmd_ff, cmd_in;
   logic [NW-1:0]       need_ff, need_in;
   logic [AW-1:0]       addr_ff, addr_in;
   ffha_pkg::entry_type upd_ff, upd_in;
   ffha_pkg::entry_type new_ff, new_in;
   ffha_pkg::entry_type prv_ff, prv_in;
   logic [AW-1:0]       nxt_len_ff, nxt_len_in;
   logic                pf_ff, pf_in;
   logic                nf_ff, nf_in;
   logic [1:0]          shd_ff, shd_in;
   logic [AW-1:0]       res_addr_ff, res_addr_in;
   logic [1:0]          res_stat_ff, res_stat_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   logic [AW-1:0]       out_addr_ff, out_addr_in;
   logic [1:0]          out_stat_ff, out_stat_in;

   // decode of the entry just read
   logic                hit_alloc, hit_free, split_ok, out_free, heap_wr;
   logic [NW-1:0]       left_w, start_need, start_hdr, split_min, size_max;
   logic [ffha_pkg::HEAP_BITS-1:0] heap_clip;
   logic [AW-1:0]       len0;
   logic [SW-1:0]       merge_sum;
   logic [1:0]          merge_d;

   assign heap_wr   = csr_wr_en && (csr_index == ffha_pkg::CSR_HEAP_BYTES);
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign left_w    = {1'b0, rdata_ff.length} - need_ff;
   assign start_need = {1'b0, rdata_ff.start} + need_ff;
   assign start_hdr = {1'b0, rdata_ff.start} + HDR_N;
   assign split_min = NW'(minp_ff) + HDR_N;
   assign hit_alloc = !rdata_ff.used && ({1'b0, rdata_ff.length} > need_ff);
   assign hit_free  = rdata_ff.used && (start_hdr == {1'b0, addr_ff});
   assign split_ok  = (count_ff < MAX_C) && (left_w >= split_min);
   assign size_max  = (req_bus.request_size > AW'(minp_ff)) ?
                      {1'b0, req_bus.request_size} : NW'(minp_ff);

   // oversized heap clips to the address space; tiny heap gives length 0
   assign heap_clip = (heap_ff > ffha_pkg::HEAP_LIMIT) ? ffha_pkg::HEAP_LIMIT : heap_ff;
   assign len0      = (heap_clip > ffha_pkg::HEAP_BITS'(HEADER_BYTES)) ?
                      AW'(heap_clip - ffha_pkg::HEAP_BITS'(HEADER_BYTES)) : '0;

   // freed block plus free neighbours, each neighbour adds its header back
   assign merge_sum = (pf_ff ? (SW'(prv_ff.length) + HDR_S) : '0) + SW'(upd_ff.length) +
                      (nf_ff ? (SW'(nxt_len_ff) + HDR_S) : '0);
   assign merge_d   = {1'b0, pf_ff} + {1'b0, nf_ff};

   assign req_bus.ready        = (state_ff == ffha_pkg::FS_IDLE);
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.data_address = out_addr_ff;
   assign rsp_bus.status       = out_stat_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffha_pkg::FS_INIT:     state_in = ffha_pkg::FS_IDLE;
         ffha_pkg::FS_IDLE:     if (req_bus.valid) state_in = ffha_pkg::FS_SCAN_RD;
         ffha_pkg::FS_SCAN_RD:  state_in = (idx_ff >= count_ff) ? ffha_pkg::FS_DONE
                                                               : ffha_pkg::FS_SCAN_CHK;
         ffha_pkg::FS_SCAN_CHK: begin
            if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               if (hit_alloc) state_in = split_ok ? ffha_pkg::FS_SHUP_RD : ffha_pkg::FS_WR_ENT;
               else           state_in = ffha_pkg::FS_SCAN_RD;
            end else begin
               state_in = hit_free ? ffha_pkg::FS_PRV_RD : ffha_pkg::FS_SCAN_RD;
            end
         end
         ffha_pkg::FS_SHUP_RD:  state_in = (idx_ff == pos_ff) ? ffha_pkg::FS_WR_NEW
                                                             : ffha_pkg::FS_SHUP_WR;
         ffha_pkg::FS_SHUP_WR:  state_in = ffha_pkg::FS_SHUP_RD;
         ffha_pkg::FS_WR_NEW:   state_in = ffha_pkg::FS_WR_ENT;
         ffha_pkg::FS_WR_ENT:   state_in = ffha_pkg::FS_DONE;
         ffha_pkg::FS_PRV_RD:   state_in = (pos_ff == '0) ? ffha_pkg::FS_NXT_RD
                                                         : ffha_pkg::FS_PRV_CHK;
         ffha_pkg::FS_PRV_CHK:  state_in = ffha_pkg::FS_NXT_RD;
         ffha_pkg::FS_NXT_RD:   state_in = ((pos_ff + 1'b1) < count_ff) ? ffha_pkg::FS_NXT_CHK
                                                                       : ffha_pkg::FS_MERGE;
         ffha_pkg::FS_NXT_CHK:  state_in = ffha_pkg::FS_MERGE;
         ffha_pkg::FS_MERGE:    state_in = (merge_d == 2'd0) ? ffha_pkg::FS_DONE
                                                            : ffha_pkg::FS_SHDN_RD;
         ffha_pkg::FS_SHDN_RD:  state_in = ((idx_ff + CW'(shd_ff)) >= count_ff) ?
                                          ffha_pkg::FS_DONE : ffha_pkg::FS_SHDN_WR;
         ffha_pkg::FS_SHDN_WR:  state_in = ffha_pkg::FS_SHDN_RD;
         ffha_pkg::FS_DONE:     if (out_free) state_in = ffha_pkg::FS_IDLE;
         default:               state_in = ffha_pkg::FS_INIT;
      endcase
      // a new heap size restarts the table
      if (heap_wr) state_in = ffha_pkg::FS_INIT;
   end

   // datapath and memory control
   always_comb begin
      heap_in     = heap_ff;
      minp_in     = minp_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      cmd_in      = cmd_ff;
      need_in     = need_ff;
      addr_in     = addr_ff;
      upd_in      = upd_ff;
      new_in      = new_ff;
      prv_in      = prv_ff;
      nxt_len_in  = nxt_len_ff;
      pf_in       = pf_ff;
      nf_in       = nf_ff;
      shd_in      = shd_ff;
      res_addr_in = res_addr_ff;
      res_stat_in = res_stat_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_addr_in  = out_addr_ff;
      out_stat_in  = out_stat_ff;
      rd_addr     = idx_ff[IW-1:0];
      wr_en       = 1'b0;
      wr_addr     = pos_ff[IW-1:0];
      wr_data     = upd_ff;

      if (csr_wr_en) begin
         if (csr_index == ffha_pkg::CSR_HEAP_BYTES) heap_in = csr_wdata;
         else                                        minp_in = csr_wdata[ffha_pkg::MINP_BITS-1:0];
      end

      case (state_ff)
         ffha_pkg::FS_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{start: '0, length: len0, used: 1'b0};
            count_in = CW'(1);
         end
         ffha_pkg::FS_IDLE: begin
            cmd_in  = req_bus.command;
            need_in = size_max + HDR_N;
            addr_in = req_bus.free_address;
            idx_in  = '0;
         end
         ffha_pkg::FS_SCAN_RD: begin
            res_addr_in = '0;
            res_stat_in = (cmd_ff == ffha_pkg::CMD_ALLOC) ? ffha_pkg::STAT_NO_FIT
                                                          : ffha_pkg::STAT_BAD_FREE;
         end
         ffha_pkg::FS_SCAN_CHK: begin
            idx_in = idx_ff + 1'b1;
            if (cmd_ff == ffha_pkg::CMD_ALLOC && hit_alloc) begin
               pos_in      = idx_ff;
               res_addr_in = start_hdr[AW-1:0];
               res_stat_in = ffha_pkg::STAT_OK;
               if (split_ok) begin
                  upd_in = '{start: rdata_ff.start, length: AW'(need_ff - HDR_N), used: 1'b1};
                  new_in = '{start: start_need[AW-1:0], length: left_w[AW-1:0], used: 1'b0};
                  idx_in = count_ff - 1'b1;
               end else begin
                  upd_in = '{start: rdata_ff.start, length: rdata_ff.length, used: 1'b1};
               end
            end else if (cmd_ff == ffha_pkg::CMD_FREE && hit_free) begin
               pos_in      = idx_ff;
               upd_in      = rdata_ff;
               res_addr_in = '0;
               res_stat_in = ffha_pkg::STAT_OK;
            end
         end
         ffha_pkg::FS_SHUP_WR: begin
            // move one entry up to open the slot after the split block
            wr_en   = 1'b1;
            wr_addr = IW'(idx_ff + 1'b1);
            wr_data = rdata_ff;
            idx_in  = idx_ff - 1'b1;
         end
         ffha_pkg::FS_WR_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(pos_ff + 1'b1);
            wr_data  = new_ff;
            count_in = count_ff + 1'b1;
         end
         ffha_pkg::FS_WR_ENT: begin
            wr_en = 1'b1;
         end
         ffha_pkg::FS_PRV_RD: begin
            rd_addr = IW'(pos_ff - 1'b1);
            pf_in   = 1'b0;
         end
         ffha_pkg::FS_PRV_CHK: begin
            prv_in = rdata_ff;
            pf_in  = !rdata_ff.used;
         end
         ffha_pkg::FS_NXT_RD: begin
            rd_addr = IW'(pos_ff + 1'b1);
            nf_in   = 1'b0;
         end
         ffha_pkg::FS_NXT_CHK: begin
            nxt_len_in = rdata_ff.length;
            nf_in      = !rdata_ff.used;
         end
         ffha_pkg::FS_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = pf_ff ? IW'(pos_ff - 1'b1) : pos_ff[IW-1:0];
            wr_data = '{start: (pf_ff ? prv_ff.start : upd_ff.start),
                        length: merge_sum[AW-1:0], used: 1'b0};
            idx_in  = pf_ff ? pos_ff : (pos_ff + 1'b1);
            shd_in  = merge_d;
         end
         ffha_pkg::FS_SHDN_RD: begin
            rd_addr = IW'(idx_ff + CW'(shd_ff));
            if ((idx_ff + CW'(shd_ff)) >= count_ff) count_in = count_ff - CW'(shd_ff);
         end
         ffha_pkg::FS_SHDN_WR: begin
            // close the gap left by merged entries
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = rdata_ff;
            idx_in  = idx_ff + 1'b1;
         end
         ffha_pkg::FS_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = res_addr_ff;
               out_stat_in  = res_stat_ff;
            end
         end
         default: ;
      endcase
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::FS_INIT;
         heap_ff      <= ffha_pkg::HEAP_RESET;
         minp_ff      <= ffha_pkg::MIN_PART_RESET;
         count_ff     <= CW'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         minp_ff      <= minp_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      cmd_ff      <= cmd_in;
      need_ff     <= need_in;
      addr_ff     <= addr_in;
      upd_ff      <= upd_in;
      new_ff      <= new_in;
      prv_ff      <= prv_in;
      nxt_len_ff  <= nxt_len_in;
      pf_ff       <= pf_in;
      nf_ff       <= nf_in;
      shd_ff      <= shd_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      out_addr_ff <= out_addr_in;
      out_stat_ff <= out_stat_in;
   end

endmodule

// ===== rtl/core/ffha_checker.sv =====
// Port-level checker for the first-fit heap allocator, with its bind.
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ffha_pkg::ADDR_BITS-1:0]  rsp_data_address,
   input logic [1:0]                      rsp_status
);

   `FFHA_ASSERT_NOW(a_status_code, rsp_valid, (rsp_status == ffha_pkg::STAT_OK || rsp_status == ffha_pkg::STAT_NO_FIT || rsp_status == ffha_pkg::STAT_BAD_FREE), "undefined status code")
   `FFHA_ASSERT_NOW(a_fail_no_addr, rsp_valid && rsp_status != ffha_pkg::STAT_OK, rsp_data_address == '0, "failed request carries an address")
   `FFHA_ASSERT_NOW(a_addr_past_hdr, rsp_valid && rsp_data_address != '0, rsp_data_address >= ffha_pkg::ADDR_BITS'(ffha_pkg::HEADER_BYTES_DEF), "granted offset inside first header")
   `FFHA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_address) && $stable(rsp_status), "stalled response changed")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_data_address (rsp_bus.data_address),
   .rsp_status       (rsp_bus.status)
);
